FILE: src/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: op codes, control
// characters, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // field widths
   localparam int OP_W    = 2;
   localparam int CH_W    = 8;
   localparam int COLOR_W = 4;
   localparam int ATTR_W  = 8;
   localparam int IDX_W   = 11;
   localparam int WORD_W  = 16;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // op codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // control and blank characters
   localparam logic [CH_W-1:0] CH_BS    = 8'h08;
   localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

   // last printable character
   localparam logic [CH_W-1:0] CH_PRINT_LAST = 8'h7F;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_ATTR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_TOP   = 2'd1;

   // register reset values
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'h02;
   localparam logic [ROW_W-1:0]  SCROLL_TOP_RST   = 5'd8;

   // cell ram strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tcw_mem_cmd_type;

endpackage : tcw_pkg
`default_nettype wire

FILE: src/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: a cell ram of attribute/character words, a
// cursor, and put, clear and read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result word
// (cursor location and, for a read, the cell word) shows on the rsp_ ports
// for one cycle with rsp_valid and must be taken then. A put that does not
// scroll, an out-of-range read and an unknown op answer in the next cycle
// and leave busy low. A read waits in a state for the registered ram data,
// then answers. A put that scrolls copies the rows below the scroll top up
// one row when the scroll top is above the last row, then blanks the last
// row; a clear blanks every cell. The sweeps write through the single write
// port of the cell ram, one word per cycle. Registers may be written while
// busy is low and no result is pending.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // command
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [tcw_pkg::OP_W-1:0]          req_op,
   input  wire logic [tcw_pkg::CH_W-1:0]          req_ch,
   input  wire logic                              req_use_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]       req_bg_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]       req_fg_color,
   input  wire logic [tcw_pkg::IDX_W-1:0]         req_cell_index,
   // result
   output logic                                   rsp_valid,
   output logic      [tcw_pkg::IDX_W-1:0]         rsp_cursor_pos,
   output logic      [tcw_pkg::WORD_W-1:0]        rsp_read_data,
   // registers
   input  wire logic                              csr_we,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcw_pkg::*;

   localparam int AW = $clog2(COLUMNS * ROWS);

   tcw_mem_cmd_type   mem_cmd;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_rdata;

   // sequencer
   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_ch         (req_ch),
      .req_use_color  (req_use_color),
      .req_bg_color   (req_bg_color),
      .req_fg_color   (req_fg_color),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_read_data  (rsp_read_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mem_cmd        (mem_cmd),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   // cell store
   tcw_cell_ram #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cell_ram (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule : text_console_writer
`default_nettype wire

FILE: src/tcw_cell_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Cell store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                             clock,
   input  wire tcw_pkg::tcw_mem_cmd_type         mem_cmd,
   input  wire logic [$clog2(COLUMNS*ROWS)-1:0]  mem_waddr,
   input  wire logic [tcw_pkg::WORD_W-1:0]       mem_wdata,
   input  wire logic [$clog2(COLUMNS*ROWS)-1:0]  mem_raddr,
   output logic      [tcw_pkg::WORD_W-1:0]       mem_rdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   logic [WORD_W-1:0] cells_mem [CELLS];
   logic [WORD_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rdata_ff <= cells_mem[mem_raddr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule : tcw_cell_ram
`default_nettype wire

FILE: src/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console: cursor, registers, character decode, and
// the scroll and clear sweeps over the cell ram.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // command
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [tcw_pkg::OP_W-1:0]          req_op,
   input  wire logic [tcw_pkg::CH_W-1:0]          req_ch,
   input  wire logic                              req_use_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]       req_bg_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]       req_fg_color,
   input  wire logic [tcw_pkg::IDX_W-1:0]         req_cell_index,
   // result
   output logic                                   rsp_valid,
   output logic      [tcw_pkg::IDX_W-1:0]         rsp_cursor_pos,
   output logic      [tcw_pkg::WORD_W-1:0]        rsp_read_data,
   // registers
   input  wire logic                              csr_we,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // cell ram
   output tcw_pkg::tcw_mem_cmd_type               mem_cmd,
   output logic      [$clog2(COLUMNS*ROWS)-1:0]   mem_waddr,
   output logic      [tcw_pkg::WORD_W-1:0]        mem_wdata,
   output logic      [$clog2(COLUMNS*ROWS)-1:0]   mem_raddr,
   input  wire logic [tcw_pkg::WORD_W-1:0]        mem_rdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = (AW > IDX_W) ? AW : IDX_W;
   localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] COLUMNS_A     = AW'(COLUMNS);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RDWAIT = 3'd1;
   localparam logic [2:0] ST_COPY   = 3'd2;
   localparam logic [2:0] ST_BLANK  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [ATTR_W-1:0] blank_attr_ff, blank_attr_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              wr_ram_ff, wr_ram_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ATTR_W-1:0] default_attr_ff;
   logic [ROW_W-1:0]  scroll_top_ff;

   logic [COL_W-1:0]  p_col;
   logic [ROW_W-1:0]  p_row;
   logic              p_wr;
   logic              p_scroll;
   logic [ATTR_W-1:0] attr;
   logic [AW-1:0]     pos;
   logic [IW-1:0]     pos_ext;
   logic [IW-1:0]     idx_ext;
   logic              idx_ok;
   logic              copy_ok;
   logic [AW-1:0]     copy_start;

   // cursor location and read address
   assign pos     = AW'(AW'(row_ff) * COLUMNS_A + AW'(col_ff));
   assign pos_ext = IW'(pos);
   assign idx_ext = IW'(req_cell_index);
   assign idx_ok  = idx_ext < IW'(CELLS);

   // scroll region: rows from top+1 move up one row when top is above the last row
   assign copy_ok    = ({1'b0, scroll_top_ff} + 6'd1) < 6'(ROWS);
   assign copy_start = AW'(AW'({1'b0, scroll_top_ff} + 6'd1) * COLUMNS_A);

   assign attr = req_use_color ? {req_bg_color, req_fg_color} : default_attr_ff;

   // character decode, line wrap and scroll detect
   always_comb begin
      p_col    = col_ff;
      p_row    = row_ff;
      p_wr     = 1'b0;
      p_scroll = 1'b0;
      if (req_ch == CH_BS && col_ff != '0) begin
         p_col = col_ff - 7'd1;
      end else if (req_ch == CH_CR) begin
         p_col = '0;
      end else if (req_ch == CH_LF) begin
         p_col = '0;
         p_row = row_ff + 5'd1;
      end else if (!req_ch[7] && req_ch[6:5] != 2'b00) begin
         p_wr  = 1'b1;
         p_col = col_ff + 7'd1;
      end
      if (p_col >= COL_W'(COLUMNS)) begin
         p_col = '0;
         p_row = p_row + 5'd1;
      end
      if (p_row >= ROW_W'(ROWS)) begin
         p_scroll = 1'b1;
         p_row    = ROW_W'(ROWS - 1);
      end
   end

   // sequencer; copy writes trail their reads through the write stage, and a
   // copy write always lands a row and one word behind the next read, so
   // no read can see a stale word
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cnt_in        = cnt_ff;
      blank_attr_in = blank_attr_ff;
      wr_valid_in   = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_ram_in     = wr_ram_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_cmd.wr_en = wr_valid_ff;
      mem_cmd.rd_en = 1'b0;
      mem_waddr     = wr_addr_ff;
      mem_wdata     = wr_ram_ff ? mem_rdata : {blank_attr_ff, CH_SPACE};
      mem_raddr     = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in = '0;
               unique case (req_op)
                  OP_PUT: begin
                     col_in        = p_col;
                     row_in        = p_row;
                     mem_cmd.wr_en = p_wr;
                     mem_waddr     = pos;
                     mem_wdata     = {attr, req_ch};
                     blank_attr_in = attr;
                     if (p_scroll && copy_ok) begin
                        state_in = ST_COPY;
                        cnt_in   = copy_start;
                     end else if (p_scroll) begin
                        state_in = ST_BLANK;
                        cnt_in   = LAST_ROW_BASE;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     blank_attr_in = default_attr_ff;
                     cnt_in        = '0;
                     state_in      = ST_BLANK;
                  end
                  OP_READ: begin
                     if (idx_ok) begin
                        mem_cmd.rd_en = 1'b1;
                        mem_raddr     = idx_ext[AW-1:0];
                        state_in      = ST_RDWAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            rsp_data_in  = mem_rdata;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            mem_cmd.rd_en = 1'b1;
            wr_valid_in   = 1'b1;
            wr_addr_in    = cnt_ff - COLUMNS_A;
            wr_ram_in     = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_BLANK;
               cnt_in   = LAST_ROW_BASE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_BLANK: begin
            wr_valid_in = 1'b1;
            wr_addr_in  = cnt_ff;
            wr_ram_in   = 1'b0;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_FINISH: begin
            rsp_data_in  = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      blank_attr_ff <= blank_attr_in;
      wr_addr_ff    <= wr_addr_in;
      wr_ram_ff     <= wr_ram_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= DEFAULT_ATTR_RST;
         scroll_top_ff   <= SCROLL_TOP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEFAULT_ATTR: default_attr_ff <= csr_wdata;
            REG_SCROLL_TOP:   scroll_top_ff   <= csr_wdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // outputs
   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_cursor_pos = pos_ext[IDX_W-1:0];

   // cursor stays on the screen
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLUMNS)) && (row_ff < ROW_W'(ROWS)))
      else $error("cursor off the screen");

   // the write stage is drained before the sequencer returns to idle
   a_stage_drained: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> state_ff != ST_IDLE)
      else $error("write stage busy in idle");

   // copy read runs exactly one row and one word ahead of its write
   a_copy_spacing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && wr_valid_ff) |->
         cnt_ff == AW'(wr_addr_ff + COLUMNS_A + AW'(1)))
      else $error("copy read and write out of step");

   // a sweep always ends in a result
   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_valid)
      else $error("sweep ended without a result");

   // a read leaves its wait state with a result and a return to idle
   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RDWAIT |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("read result missing");

endmodule : tcw_ctrl
`default_nettype wire

FILE: tb/tcw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// Watches the command, result and register ports of the text console writer.
// It keeps its own screen image, cursor and register copies, works out the
// cursor location and cell word for every accepted command, and compares
// each result word field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [tcw_pkg::OP_W-1:0]          req_op,
   input  wire logic [tcw_pkg::CH_W-1:0]          req_ch,
   input  wire logic                              req_use_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]       req_bg_color,
   input  wire logic [tcw_pkg::COLOR_W-1:0]       req_fg_color,
   input  wire logic [tcw_pkg::IDX_W-1:0]         req_cell_index,
   input  wire logic                              rsp_valid,
   input  wire logic [tcw_pkg::IDX_W-1:0]         rsp_cursor_pos,
   input  wire logic [tcw_pkg::WORD_W-1:0]        rsp_read_data,
   input  wire logic                              csr_we,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                     mismatch_count,
   output int                                     pending_words
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct packed {
      logic [IDX_W-1:0]  cursor_pos;
      logic [WORD_W-1:0] read_data;
   } cursor_report_type;

   // predicted screen, cursor and registers
   logic [WORD_W-1:0] screen [CELLS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [ATTR_W-1:0] attr_reg;
   logic [ROW_W-1:0]  scroll_top_reg;

   cursor_report_type expected_reports [$];

   function automatic void report_failure(input string msg);
      if (mismatch_count < 10) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endfunction

   // work out the cursor and cell word that one command leaves behind
   task automatic console_step(
      input logic [OP_W-1:0]    op,
      input logic [CH_W-1:0]    ch,
      input logic               use_color,
      input logic [COLOR_W-1:0] bg,
      input logic [COLOR_W-1:0] fg,
      input logic [IDX_W-1:0]   idx
   );
      logic [ATTR_W-1:0] attr;
      logic [WORD_W-1:0] word;
      int unsigned       loc;
      int unsigned       pos;
      int unsigned       top;
      int unsigned       i;
      cursor_report_type rpt;
      word = '0;
      case (op)
         OP_PUT: begin
            attr = use_color ? {bg, fg} : attr_reg;
            loc  = cur_row * COLUMNS + cur_col;
            if (ch == CH_BS && cur_col != 0) begin
               cur_col = cur_col - 1;
            end else if (ch == CH_CR) begin
               cur_col = 0;
            end else if (ch == CH_LF) begin
               cur_col = 0;
               cur_row = cur_row + 1;
            end else if (ch >= CH_SPACE && ch <= CH_PRINT_LAST) begin
               if (loc < CELLS) screen[loc] = {attr, ch};
               cur_col = cur_col + 1;
            end
            // line wrap
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row = cur_row + 1;
            end
            // scroll the region below the scroll top, blank the last row
            if (cur_row >= ROWS) begin
               top = scroll_top_reg;
               for (i = top * COLUMNS; i < COLUMNS * (ROWS - 1); i++) begin
                  screen[i] = screen[i + COLUMNS];
               end
               for (i = COLUMNS * (ROWS - 1); i < CELLS; i++) begin
                  screen[i] = {attr, CH_SPACE};
               end
               cur_row = ROWS - 1;
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < CELLS; i++) begin
               screen[i] = {attr_reg, CH_SPACE};
            end
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            if (idx < CELLS) word = screen[idx];
         end
         default: begin
         end
      endcase
      pos = cur_row * COLUMNS + cur_col;
      rpt.cursor_pos = pos[IDX_W-1:0];
      rpt.read_data  = word;
      expected_reports.push_back(rpt);
   endtask

   // watch all three ports on the rising edge
   always @(posedge clock) begin : watch_ports
      cursor_report_type want;
      if (reset) begin
         cur_col        = 0;
         cur_row        = 0;
         attr_reg       = DEFAULT_ATTR_RST;
         scroll_top_reg = SCROLL_TOP_RST;
         mismatch_count = 0;
         expected_reports.delete();
      end else begin
         // result word against the oldest prediction
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               report_failure($sformatf("result word with nothing expected, cursor_pos %0d",
                                        rsp_cursor_pos));
            end else begin
               want = expected_reports.pop_front();
               if (rsp_cursor_pos !== want.cursor_pos) begin
                  report_failure($sformatf("cursor_pos expected %0d, got %0d",
                                           want.cursor_pos, rsp_cursor_pos));
               end
               if (rsp_read_data !== want.read_data) begin
                  report_failure($sformatf("read_data expected %04h, got %04h",
                                           want.read_data, rsp_read_data));
               end
            end
         end
         // register writes, unknown indexes change nothing
         if (csr_we) begin
            case (csr_index)
               REG_DEFAULT_ATTR: attr_reg = csr_wdata;
               REG_SCROLL_TOP:   scroll_top_reg = csr_wdata[ROW_W-1:0];
               default: begin
               end
            endcase
         end
         // accepted command word
         if (start && !busy) begin
            console_step(req_op, req_ch, req_use_color, req_bg_color, req_fg_color,
                         req_cell_index);
         end
      end
      pending_words = expected_reports.size();
   end

endmodule : tcw_checker
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the text console writer. A directed opening covers reads out
// of range, clear, printable extremes, ignored codes, backspace at column 0,
// CR, LF and an unknown op; then register phases run random command streams
// with line-feed bursts that reach scrolling, a text-only phase that wraps
// lines, and random gaps on the command side. tcw_checker does the checking.
// ----------------------------------------------------------------------------
module tb_top;
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS_DEF * ROWS_DEF;
   localparam int IDX_MAX = (1 << IDX_W) - 1;
   localparam logic [OP_W-1:0]      OP_NONE       = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B   = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OP_W-1:0]       req_op;
   logic [CH_W-1:0]       req_ch;
   logic                  req_use_color;
   logic [COLOR_W-1:0]    req_bg_color;
   logic [COLOR_W-1:0]    req_fg_color;
   logic [IDX_W-1:0]      req_cell_index;
   logic                  rsp_valid;
   logic [IDX_W-1:0]      rsp_cursor_pos;
   logic [WORD_W-1:0]     rsp_read_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    pending_words;
   bit                    gaps_on;

   text_console_writer dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_ch         (req_ch),
      .req_use_color  (req_use_color),
      .req_bg_color   (req_bg_color),
      .req_fg_color   (req_fg_color),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_read_data  (rsp_read_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   tcw_checker console_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_ch         (req_ch),
      .req_use_color  (req_use_color),
      .req_bg_color   (req_bg_color),
      .req_fg_color   (req_fg_color),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_read_data  (rsp_read_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // random gap on the command side, mostly short, now and then long
   task automatic pace();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (!gaps_on || pick < 55) n = 0;
      else if (pick < 88) n = $urandom_range(3, 1);
      else if (pick < 97) n = $urandom_range(12, 4);
      else n = $urandom_range(60, 20);
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // offer one command word and hold it until taken
   task automatic send_word(
      input logic [OP_W-1:0]    op,
      input logic [CH_W-1:0]    ch,
      input logic               use_color,
      input logic [COLOR_W-1:0] bg,
      input logic [COLOR_W-1:0] fg,
      input logic [IDX_W-1:0]   idx
   );
      start          <= 1'b1;
      req_op         <= op;
      req_ch         <= ch;
      req_use_color  <= use_color;
      req_bg_color   <= bg;
      req_fg_color   <= fg;
      req_cell_index <= idx;
      while (busy) @(negedge clock);
      @(negedge clock);
      pace();
   endtask

   // stop sending until every result word is back
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_words != 0 || busy) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // one random command; text mode sends only printable characters and reads, so only line wrap resets the column
   task automatic random_word(input bit text_only);
      int unsigned        pick;
      logic [OP_W-1:0]    op;
      logic [CH_W-1:0]    ch;
      logic               use_color;
      logic [COLOR_W-1:0] bg;
      logic [COLOR_W-1:0] fg;
      logic [IDX_W-1:0]   idx;
      op        = OP_PUT;
      ch        = CH_W'($urandom_range(255));
      use_color = 1'($urandom_range(1));
      bg        = COLOR_W'($urandom_range(15));
      fg        = COLOR_W'($urandom_range(15));
      idx       = IDX_W'($urandom_range(CELLS - 1));
      pick      = $urandom_range(99);
      if (text_only) pick = (pick < 90) ? 0 : 70;
      if (pick < 44) begin
         ch = CH_W'($urandom_range(CH_PRINT_LAST, CH_SPACE));
      end else if (pick < 56) begin
         ch = CH_LF;
      end else if (pick < 60) begin
         ch = CH_CR;
      end else if (pick < 64) begin
         ch = CH_BS;
      end else if (pick < 69) begin
         // any code, mostly ignored ones
      end else if (pick < 94) begin
         op = OP_READ;
         if ($urandom_range(7) == 0) idx = IDX_W'($urandom_range(IDX_MAX, CELLS));
      end else if (pick < 95) begin
         op = OP_CLEAR;
      end else begin
         op = OP_NONE;
      end
      send_word(op, ch, use_color, bg, fg, idx);
   endtask

   initial begin
      int unsigned       p;
      int unsigned       n;
      logic [ATTR_W-1:0] attr;
      logic [ROW_W-1:0]  top;
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_PUT;
      req_ch         = '0;
      req_use_color  = 1'b0;
      req_bg_color   = '0;
      req_fg_color   = '0;
      req_cell_index = '0;
      csr_we         = 1'b0;
      csr_index      = REG_DEFAULT_ATTR;
      csr_wdata      = '0;
      gaps_on        = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: out-of-range reads need no written cell
      send_word(OP_READ, 8'h00, 1'b0, 4'h0, 4'h0, IDX_W'(IDX_MAX));
      send_word(OP_READ, 8'hFF, 1'b1, 4'hF, 4'hF, IDX_W'(CELLS));
      // clear writes every cell with the reset attribute
      send_word(OP_CLEAR, 8'h00, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_READ, 8'h00, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_READ, 8'h00, 1'b0, 4'h0, 4'h0, IDX_W'(CELLS - 1));
      // printable extremes, default and colour pair attributes
      send_word(OP_PUT, CH_SPACE, 1'b0, 4'hF, 4'hF, 11'd0);
      send_word(OP_PUT, CH_PRINT_LAST, 1'b1, 4'hF, 4'hF, 11'd0);
      send_word(OP_PUT, 8'h41, 1'b1, 4'h0, 4'h0, 11'd0);
      // ignored codes
      send_word(OP_PUT, 8'h80, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_PUT, 8'hFF, 1'b1, 4'hF, 4'hF, IDX_W'(IDX_MAX));
      send_word(OP_PUT, 8'h00, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_READ, 8'h00, 1'b0, 4'h0, 4'h0, 11'd1);
      send_word(OP_READ, 8'h00, 1'b0, 4'h0, 4'h0, 11'd2);
      // backspace down to column 0 and once more there
      repeat (4) send_word(OP_PUT, CH_BS, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_PUT, 8'h7A, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_PUT, CH_CR, 1'b0, 4'h0, 4'h0, 11'd0);
      send_word(OP_PUT, CH_LF, 1'b1, 4'h5, 4'hA, 11'd0);
      // unknown op changes nothing
      send_word(OP_NONE, 8'hFF, 1'b1, 4'hF, 4'hF, IDX_W'(IDX_MAX));
      send_word(OP_READ, 8'h00, 1'b0, 4'h0, 4'h0, 11'd0);

      // register phases with random streams
      for (p = 0; p < 6; p++) begin
         wait_idle();
         attr = ATTR_W'($urandom_range(255));
         top  = ROW_W'($urandom_range(ROWS_DEF - 1));
         case (p)
            0: begin
               attr = 8'h00;
               top  = '0;
            end
            1: begin
               attr = 8'hFF;
               top  = ROW_W'(ROWS_DEF - 1);
            end
            2: top = ROW_W'(ROWS_DEF - 2);
            4: begin
               attr = 8'hA5;
               top  = SCROLL_TOP_RST;
            end
            default: begin
            end
         endcase
         write_reg(REG_DEFAULT_ATTR, attr);
         write_reg(REG_SCROLL_TOP, CSR_DATA_W'(top));
         if (p == 1) write_reg(REG_SPARE_A, CSR_DATA_W'($urandom_range(255)));
         if (p == 4) write_reg(REG_SPARE_B, CSR_DATA_W'($urandom_range(255)));
         gaps_on = (p != 3);
         if (p == 2) begin
            // long text run: wraps lines and scrolls from the bottom row
            repeat (110) random_word(1'b1);
         end else begin
            // line feed burst pushes the cursor down into scrolling
            n = (p == 0) ? ROWS_DEF : 8;
            repeat (n) begin
               if (p == 0 || $urandom_range(99) < 75) begin
                  send_word(OP_PUT, CH_LF, 1'($urandom_range(1)),
                            COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                            IDX_W'($urandom_range(IDX_MAX)));
               end else begin
                  send_word(OP_PUT, CH_W'($urandom_range(CH_PRINT_LAST, CH_SPACE)),
                            1'($urandom_range(1)), COLOR_W'($urandom_range(15)),
                            COLOR_W'($urandom_range(15)), IDX_W'($urandom_range(IDX_MAX)));
               end
            end
            repeat (28) random_word(1'b0);
         end
      end

      // drain, then watch for stray words
      start <= 1'b0;
      for (n = 0; n < 5000 && pending_words != 0; n++) @(negedge clock);
      repeat (2100) @(negedge clock);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule : tb_top
`default_nettype wire

FILE: text_console_writer.f
src/tcw_pkg.sv
src/tcw_cell_ram.sv
src/tcw_ctrl.sv
src/text_console_writer.sv
tb/tcw_checker.sv
tb/tb_top.sv
